// ===== rtl/cfc_pkg.sv =====
// cfc_pkg: constants, types and register codes for the centered fir convolution unit
// no dependencies; imported by the interfaces and every rtl module of the block
package cfc_pkg;

    // sizes of the datapath
    localparam int TAPS_MAX     = 7;
    localparam int SAMPLE_BITS  = 16;
    localparam int COEF_BITS    = 16;
    localparam int OUT_BITS     = 34;
    localparam int PROD_BITS    = SAMPLE_BITS + COEF_BITS;
    localparam int SUM_BITS     = PROD_BITS + $clog2(TAPS_MAX + 1);
    localparam int TREE_BITS    = (SUM_BITS > OUT_BITS) ? SUM_BITS : OUT_BITS;
    localparam int TREE_LEAVES  = 2 ** $clog2(TAPS_MAX + 1);

    // frame bookkeeping
    localparam int COUNT_MAX    = 7;
    localparam int COUNT_BITS   = $clog2(COUNT_MAX + 1);
    localparam int TAP_CNT_BITS = 3;
    localparam int TAP_IDX_BITS = (TAPS_MAX > 1) ? $clog2(TAPS_MAX) : 1;
    localparam int LAG_MAX      = TAPS_MAX - 1 - TAPS_MAX / 2;
    localparam int LAG_BITS     = (LAG_MAX > 1) ? $clog2(LAG_MAX + 1) : 1;

    // configuration port
    localparam int CFG_IDX_BITS  = $clog2(TAPS_MAX + 1);
    localparam int CFG_DATA_BITS = COEF_BITS;

    // register map
    localparam logic [CFG_IDX_BITS-1:0] REG_TAP_COUNT = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_BASE = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_LAST = CFG_IDX_BITS'(TAPS_MAX);

    // reset values
    localparam logic [TAP_CNT_BITS-1:0] TAP_COUNT_RESET = TAP_CNT_BITS'(1);
    localparam logic [COEF_BITS-1:0]    COEF0_RESET     = COEF_BITS'(16384);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [OUT_BITS-1:0]    filtered_t;

    // delay line, newest sample in slot 0
    typedef logic [TAPS_MAX-1:0][SAMPLE_BITS-1:0] line_t;
    typedef logic [TAPS_MAX-1:0][COEF_BITS-1:0]   coef_arr_t;

    // decoded configuration seen by the datapath
    typedef struct packed {
        logic [TAP_CNT_BITS-1:0] taps;
        logic [TAP_IDX_BITS-1:0] center;
        logic [LAG_BITS-1:0]     lag;
        coef_arr_t               coef;
    } cfg_t;

    // one output to compute: t samples behind the newest one
    typedef struct packed {
        logic                valid;
        logic                flush;
        logic [LAG_BITS-1:0] t;
    } job_t;

endpackage

// ===== rtl/cfc_sample_if.sv =====
// cfc_sample_if: valid/ready channel carrying one input sample transaction
// depends on cfc_pkg
interface cfc_sample_if
    import cfc_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample;
    logic    final_sample;

    modport source (output valid, output sample, output final_sample, input ready);
    modport sink   (input valid, input sample, input final_sample, output ready);
endinterface

// ===== rtl/cfc_result_if.sv =====
// cfc_result_if: valid/ready channel carrying one filtered result transaction
// depends on cfc_pkg
interface cfc_result_if
    import cfc_pkg::*;
();
    logic      valid;
    logic      ready;
    filtered_t filtered;
    logic      final_output;

    modport source (output valid, output filtered, output final_output, input ready);
    modport sink   (input valid, input filtered, input final_output, output ready);
endinterface

// ===== rtl/cfc_cfg_regs.sv =====
// cfc_cfg_regs: tap count and coefficient registers with the decoded kernel geometry
// depends on cfc_pkg
module cfc_cfg_regs
    import cfc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                     cfg
);

    logic [TAP_CNT_BITS-1:0] taps_reg;
    coef_arr_t               coef_reg;
    logic [TAP_CNT_BITS-1:0] taps_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg <= TAP_COUNT_RESET;
            coef_reg <= {{(TAPS_MAX-1){COEF_BITS'(0)}}, COEF0_RESET};
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_TAP_COUNT)
            begin
                taps_reg <= cfg_data[TAP_CNT_BITS-1:0];
            end
            else if (cfg_index <= REG_COEF_LAST)
            begin
                coef_reg[TAP_IDX_BITS'(cfg_index - REG_COEF_BASE)] <= cfg_data[COEF_BITS-1:0];
            end
        end
    end

    // zero taps acts as one, too many taps acts as the maximum
    always_comb
    begin
        if (taps_reg == '0)
        begin
            taps_eff = TAP_CNT_BITS'(1);
        end
        else if (taps_reg > TAP_CNT_BITS'(TAPS_MAX))
        begin
            taps_eff = TAP_CNT_BITS'(TAPS_MAX);
        end
        else
        begin
            taps_eff = taps_reg;
        end
        cfg.taps   = taps_eff;
        cfg.center = TAP_IDX_BITS'(taps_eff >> 1);
        cfg.lag    = LAG_BITS'(taps_eff - TAP_CNT_BITS'(1) - (taps_eff >> 1));
        cfg.coef   = coef_reg;
    end

endmodule

// ===== rtl/cfc_front.sv =====
// cfc_front: delay line, frame sample count and output job sequencer with flush
// depends on cfc_pkg and cfc_sample_if
module cfc_front
    import cfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    cfc_sample_if.sink  samples,
    input  logic        job_go,
    output job_t        job,
    output line_t       line
);

    line_t                 line_reg;
    line_t                 line_next;
    line_t                 base_line;
    logic [COUNT_BITS-1:0] seen_reg;
    logic [COUNT_BITS-1:0] seen_next;
    logic [COUNT_BITS-1:0] n;
    logic [COUNT_BITS-1:0] lag_ext;
    job_t                  job_reg;
    job_t                  job_next;
    logic                  flush_busy;
    logic                  clear_now;
    logic                  in_fire;

    always_comb
    begin
        flush_busy    = job_reg.valid && job_reg.flush && (job_reg.t != '0);
        clear_now     = job_go && job_reg.flush && (job_reg.t == '0);
        samples.ready = (!job_reg.valid || job_go) && !flush_busy;
        in_fire       = samples.valid && samples.ready;

        // a sample taken as the frame clears shifts into an empty line
        base_line = clear_now ? '0 : line_reg;
        n         = clear_now ? '0 : seen_reg;
        lag_ext   = COUNT_BITS'(cfg.lag);

        line_next = line_reg;
        seen_next = seen_reg;
        job_next  = job_reg;

        if (clear_now)
        begin
            line_next = '0;
            seen_next = '0;
        end

        if (in_fire)
        begin
            for (int i = TAPS_MAX - 1; i > 0; i--)
            begin
                line_next[i] = base_line[i-1];
            end
            line_next[0] = samples.sample;
            seen_next    = (n == COUNT_BITS'(COUNT_MAX)) ? n : COUNT_BITS'(n + 1'b1);
            if (samples.final_sample)
            begin
                job_next.valid = 1'b1;
                job_next.flush = 1'b1;
                job_next.t     = (n < lag_ext) ? n[LAG_BITS-1:0] : cfg.lag;
            end
            else
            begin
                job_next.valid = (n >= lag_ext);
                job_next.flush = 1'b0;
                job_next.t     = cfg.lag;
            end
        end
        else if (job_go)
        begin
            if (flush_busy)
            begin
                job_next.t = job_reg.t - 1'b1;
            end
            else
            begin
                job_next.valid = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= '0;
            seen_reg <= '0;
            job_reg  <= '0;
        end
        else
        begin
            line_reg <= line_next;
            seen_reg <= seen_next;
            job_reg  <= job_next;
        end
    end

    assign job  = job_reg;
    assign line = line_reg;

`ifndef ASSERT_OFF
    // a final sample always starts a flush sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && samples.final_sample |=> job_reg.valid && job_reg.flush)
        else $error("final sample did not start a flush");

    // flush steps count down by one toward the newest output
    assert property (@(posedge clk) disable iff (!rst_n)
        job_go && flush_busy |=> job_reg.valid && job_reg.flush &&
            (job_reg.t == $past(job_reg.t) - 1'b1))
        else $error("flush step skipped or lost");

    // the frame count restarts once the last flush output has left
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_now |=> seen_reg <= COUNT_BITS'(1))
        else $error("frame count not cleared after flush");
`endif

endmodule

// ===== rtl/cfc_mac.sv =====
// cfc_mac: per-tap product stage, adder tree and output register
// depends on cfc_pkg and cfc_result_if
module cfc_mac
    import cfc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  job_t         job,
    input  line_t        line,
    output logic         job_go,
    cfc_result_if.source results
);

    logic                    prod_valid_reg;
    logic                    prod_fin_reg;
    prod_t                   prod_reg  [TAPS_MAX];
    prod_t                   prod_next [TAPS_MAX];
    logic                    out_valid_reg;
    filtered_t               filtered_reg;
    logic                    final_reg;
    logic                    sum_go;
    logic                    prod_free;
    logic [TAP_IDX_BITS:0]   s;
    logic [TAP_IDX_BITS:0]   diff [TAPS_MAX];
    sample_t                 xs   [TAPS_MAX];
    coef_t                   hs   [TAPS_MAX];
    logic signed [TREE_BITS-1:0] node [2*TREE_LEAVES-1];

    always_comb
    begin
        sum_go    = prod_valid_reg && (!out_valid_reg || results.ready);
        prod_free = !prod_valid_reg || sum_go;
        job_go    = job.valid && prod_free;
    end

    // tap j multiplies the sample t + center - j places behind the newest
    always_comb
    begin
        s = (TAP_IDX_BITS+1)'(job.t) + (TAP_IDX_BITS+1)'(cfg.center);
        for (int j = 0; j < TAPS_MAX; j++)
        begin
            diff[j] = s - (TAP_IDX_BITS+1)'(j);
            xs[j]   = line[diff[j][TAP_IDX_BITS-1:0]];
            hs[j]   = cfg.coef[j];
            if ((TAP_CNT_BITS'(j) < cfg.taps) && (s >= (TAP_IDX_BITS+1)'(j)) &&
                (diff[j] < (TAP_IDX_BITS+1)'(TAPS_MAX)))
            begin
                prod_next[j] = xs[j] * hs[j];
            end
            else
            begin
                prod_next[j] = '0;
            end
        end
    end

    // balanced adder tree over the registered products
    always_comb
    begin
        for (int i = 0; i < TREE_LEAVES; i++)
        begin
            if (i < TAPS_MAX)
            begin
                node[TREE_LEAVES-1+i] = TREE_BITS'(prod_reg[i]);
            end
            else
            begin
                node[TREE_LEAVES-1+i] = '0;
            end
        end
        for (int i = TREE_LEAVES - 2; i >= 0; i--)
        begin
            node[i] = node[2*i+1] + node[2*i+2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_free)
            begin
                prod_valid_reg <= job.valid;
            end
            if (sum_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_go)
        begin
            prod_fin_reg <= job.flush && (job.t == '0);
            for (int j = 0; j < TAPS_MAX; j++)
            begin
                prod_reg[j] <= prod_next[j];
            end
        end
        if (sum_go)
        begin
            filtered_reg <= node[0][OUT_BITS-1:0];
            final_reg    <= prod_fin_reg;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.filtered     = filtered_reg;
    assign results.final_output = final_reg;

endmodule

// ===== rtl/centered_fir_convolution_unit.sv =====
// centered_fir_convolution_unit: top level of the same-length fir convolution block
// depends on cfc_pkg, cfc_sample_if, cfc_result_if, cfc_cfg_regs, cfc_front, cfc_mac
// pipeline: job register, per-tap product registers, output register
// throughput: one sample per cycle while results are taken; after a final sample the input
//   stalls while the flush outputs beyond the first go through the single job slot they share
// reset: clears the delay line, frame count and pipeline valids; tap count to 1, coef_0 to 16384
module centered_fir_convolution_unit
    import cfc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    cfc_sample_if.sink               samples,
    cfc_result_if.source             results
);

    // decoded kernel: effective tap count, center tap, output lag, coefficients
    cfg_t  cfg;

    // job handed from the sequencer to the product stage
    job_t  job;
    logic  job_go;

    // delay line contents, newest sample first
    line_t line;

    // configuration registers; the user must write them only while the block is idle, the block does not enforce it
    cfc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // shifts samples in, counts the frame and issues one job per output,
    // stepping through the flush outputs after a final sample
    cfc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .samples (samples),
        .job_go  (job_go),
        .job     (job),
        .line    (line)
    );

    // products registered per tap, then summed into the output register
    cfc_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .job     (job),
        .line    (line),
        .job_go  (job_go),
        .results (results)
    );

endmodule

// ===== verif/tb_centered_fir_convolution_unit.sv =====
// tb_centered_fir_convolution_unit: self-checking testbench for the same-length fir unit
// depends on cfc_pkg, cfc_sample_if, cfc_result_if and the centered_fir_convolution_unit rtl
`timescale 1ns / 100ps

module tb_centered_fir_convolution_unit;
    import cfc_pkg::*;

    // timing of the bench
    localparam int RESULT_LATENCY = 2;
    localparam int SETTLE_CYCLES  = RESULT_LATENCY + 4;
    localparam int IDLE_LIMIT     = 2000;
    localparam int LONG_HOLD      = 150;
    localparam int REPORT_MAX     = 10;
    localparam int RANDOM_ITEMS   = 400;

    // flavors of kernel loaded into the coefficient registers
    typedef enum int
    {
        KERNEL_RANDOM,
        KERNEL_SPARSE,
        KERNEL_MIN,
        KERNEL_MAX
    } kernel_kind_e;

    // stall patterns of the result side
    typedef enum int
    {
        SINK_STEADY,
        SINK_COIN,
        SINK_MOSTLY,
        SINK_EVERY_THIRD
    } sink_mode_e;

    // one expected output transaction
    typedef struct packed
    {
        filtered_t filtered;
        logic      final_output;
    } filter_out_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    cfc_sample_if sample_ch ();
    cfc_result_if result_ch ();

    centered_fir_convolution_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (sample_ch),
        .results   (result_ch)
    );

    always #10 clk = ~clk;

    // shadow of the block: registers as written, delay line newest first, frame count
    logic [TAP_CNT_BITS-1:0] tap_count_q;
    coef_t                   coefs_q [TAPS_MAX];
    sample_t                 line_q  [TAPS_MAX];
    logic [COUNT_BITS-1:0]   seen_q;

    // outputs owed by the block, oldest first
    filter_out_t pending_outputs [$];

    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int unsigned hold_request   = 0;

    // sender burst control
    bit gaps_on    = 1'b1;
    int burst_left = 0;

    // ---------------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------------

    // output for the frame position lying t samples behind the newest sample
    function automatic filtered_t conv_sum(input int t, input int k);
        longint acc;
        int     center;
        int     slot;
        acc    = 0;
        center = k / 2;
        for (int j = 0; j < k; j++)
        begin
            slot = t + center - j;
            // positions outside the frame were cleared to zero, out of range ones skipped
            if (slot >= 0 && slot < TAPS_MAX)
                acc += longint'(line_q[slot]) * longint'(coefs_q[j]);
        end
        return filtered_t'(acc);
    endfunction

    // advance the shadow by one accepted sample and queue what it owes
    task automatic predict_outputs(input sample_t s, input logic fin);
        int          k;
        int          lag;
        int          n;
        int          t;
        filter_out_t rec;
        // tap count zero acts as one tap, anything above the maximum is clamped
        if (tap_count_q == 0)
            k = 1;
        else if (tap_count_q > TAPS_MAX)
            k = TAPS_MAX;
        else
            k = tap_count_q;
        lag = k - 1 - k / 2;
        n   = seen_q;

        for (int i = TAPS_MAX - 1; i > 0; i--)
            line_q[i] = line_q[i - 1];
        line_q[0] = s;
        // count saturates; positions past six already cover the largest lag
        if (seen_q < COUNT_MAX)
            seen_q = seen_q + 1'b1;

        if (!fin)
        begin
            if (n >= lag)
            begin
                rec.filtered     = conv_sum(lag, k);
                rec.final_output = 1'b0;
                pending_outputs.push_back(rec);
            end
        end
        else
        begin
            // the final sample flushes everything still owed, oldest position first
            t = (n < lag) ? n : lag;
            while (t >= 0)
            begin
                rec.filtered     = conv_sum(t, k);
                rec.final_output = (t == 0);
                pending_outputs.push_back(rec);
                t--;
            end
            // frame state clears, registers stay
            for (int i = 0; i < TAPS_MAX; i++)
                line_q[i] = '0;
            seen_q = '0;
        end
    endtask

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------

    // one sample transaction; valid is left high so back-to-back items stream
    task automatic send_sample(input sample_t s, input logic fin);
        sample_ch.valid        <= 1'b1;
        sample_ch.sample       <= s;
        sample_ch.final_sample <= fin;
        @(posedge clk);
        while (sample_ch.ready !== 1'b1)
            @(posedge clk);
        predict_outputs(s, fin);
    endtask

    // send with the sender's burst and gap pattern applied
    task automatic offer_sample(input sample_t s, input logic fin);
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                sample_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
            else
                burst_left = 1000;
        end
        burst_left--;
        send_sample(s, fin);
    endtask

    // mostly random bits, with the corner values showing up often
    function automatic sample_t pick_sample();
        case ($urandom_range(0, 15))
            0:       return sample_t'(-32768);
            1:       return sample_t'(32767);
            2:       return sample_t'(0);
            3:       return sample_t'(-1);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++)
            offer_sample(pick_sample(), i == len - 1);
    endtask

    // stop offering, then wait for every owed output plus the pipeline depth,
    // which also covers samples still in flight that owe nothing
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write the tap count and all seven coefficients; only called with the block drained
    task automatic apply_config(input logic [TAP_CNT_BITS-1:0] taps, input kernel_kind_e kind);
        logic [CFG_DATA_BITS-1:0] value;
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_TAP_COUNT;
        cfg_data  <= CFG_DATA_BITS'(taps);
        @(posedge clk);
        tap_count_q = taps;
        for (int j = 0; j < TAPS_MAX; j++)
        begin
            case (kind)
                KERNEL_MIN:    value = 16'h8000;
                KERNEL_MAX:    value = 16'h7fff;
                KERNEL_SPARSE: value = ($urandom_range(0, 2) == 0) ? 16'(0) : 16'($urandom);
                default:       value = 16'($urandom);
            endcase
            cfg_wr_en <= 1'b1;
            cfg_index <= REG_COEF_BASE + CFG_IDX_BITS'(j);
            cfg_data  <= value;
            @(posedge clk);
            coefs_q[j] = coef_t'(value);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // reset kernel is a single tap at one half: every sample gives one output
    task automatic test_reset_kernel();
        send_sample(sample_t'(32767), 1'b0);
        send_sample(sample_t'(-32768), 1'b0);
        send_sample(sample_t'(0), 1'b1);
        wait_drained();
    endtask

    // full kernel of the most negative taps on the most negative samples gives
    // the largest sum; a long frame runs the count into saturation, then a
    // one-sample frame flushes a single output
    task automatic test_extreme_sums();
        apply_config(3'd7, KERNEL_MIN);
        for (int i = 0; i < 8; i++)
            send_sample(sample_t'(-32768), i == 7);
        send_sample(sample_t'(12345), 1'b1);
        wait_drained();
    endtask

    // a tap count of zero behaves as one tap
    task automatic test_tap_count_zero();
        apply_config(3'd0, KERNEL_RANDOM);
        send_sample(pick_sample(), 1'b0);
        send_sample(sample_t'($urandom), 1'b0);
        send_sample(sample_t'($urandom), 1'b1);
        wait_drained();
    endtask

    // new registers take effect mid frame while held samples keep their places;
    // the most positive kernel on negative samples reaches the smallest sum
    task automatic test_config_mid_frame();
        apply_config(3'd3, KERNEL_RANDOM);
        for (int i = 0; i < 3; i++)
            send_sample(sample_t'(-32768), 1'b0);
        wait_drained();
        apply_config(3'd7, KERNEL_MAX);
        for (int i = 0; i < 5; i++)
            send_sample(sample_t'(-32768), i == 4);
        wait_drained();
    endtask

    // result side holds off for a long stretch while samples keep coming, so the
    // block fills up and stalls its input
    task automatic test_output_backpressure();
        apply_config(3'd6, KERNEL_RANDOM);
        gaps_on      = 1'b0;
        hold_request = LONG_HOLD;
        send_frame(9);
        send_frame(14);
        send_frame(2);
        send_frame(15);
        gaps_on = 1'b1;
        wait_drained();
    endtask

    // phases of random kernels, including the extremes, with random framing
    task automatic test_random_frames();
        int sent;
        int phase;
        int phase_sent;
        int phase_len;
        int len;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_drained();
            case (phase)
                0:       apply_config(3'd7, KERNEL_MAX);
                1:       apply_config(3'd1, KERNEL_MIN);
                2:       apply_config(3'd0, KERNEL_SPARSE);
                3:       apply_config(3'd2, KERNEL_RANDOM);
                default: apply_config(3'($urandom_range(0, 7)),
                                      kernel_kind_e'($urandom_range(0, 3)));
            endcase
            gaps_on    = ($urandom_range(0, 3) != 0);
            phase_sent = 0;
            phase_len  = $urandom_range(25, 60);
            while (phase_sent < phase_len)
            begin
                // mostly short frames, now and then one long enough to saturate the count
                if ($urandom_range(0, 5) == 0)
                    len = $urandom_range(8, 16);
                else
                    len = $urandom_range(1, 7);
                send_frame(len);
                phase_sent += len;
                // sender sometimes pauses until every owed output is out
                if ($urandom_range(0, 7) == 0)
                    wait_drained();
            end
            sent += phase_sent;
            phase++;
        end
        wait_drained();
    endtask

    // ---------------------------------------------------------------------
    // result side: stall pattern of its own, plus the long hold on request
    // ---------------------------------------------------------------------
    initial
    begin : result_sink
        int         seg_left;
        int         cycle_cnt;
        int         hold;
        sink_mode_e mode;
        seg_left  = 0;
        cycle_cnt = 0;
        mode      = SINK_STEADY;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold         = hold_request;
                hold_request = 0;
                result_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            if (seg_left == 0)
            begin
                mode     = sink_mode_e'($urandom_range(0, 3));
                seg_left = $urandom_range(5, 60);
            end
            seg_left--;
            cycle_cnt++;
            case (mode)
                SINK_STEADY:      result_ch.ready <= 1'b1;
                SINK_COIN:        result_ch.ready <= 1'($urandom_range(0, 1));
                SINK_MOSTLY:      result_ch.ready <= ($urandom_range(0, 3) != 0);
                SINK_EVERY_THIRD: result_ch.ready <= (cycle_cnt % 3 != 0);
                default:          result_ch.ready <= 1'b1;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // checking: each output transaction against the oldest expectation
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : output_check
        filter_out_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (pending_outputs.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected output: filtered %0d final %0b",
                             result_ch.filtered, result_ch.final_output);
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (result_ch.filtered !== want.filtered
                    || result_ch.final_output !== want.final_output)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("output mismatch: expected %0d final %0b, got %0d final %0b",
                                 want.filtered, want.final_output,
                                 result_ch.filtered, result_ch.final_output);
                end
            end
        end
    end

    // watchdog: too long without a transaction on either channel ends the run
    always @(posedge clk)
    begin
        if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1)
            || (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_centered_fir_convolution_unit NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_index              = REG_TAP_COUNT;
        cfg_data               = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.sample       = '0;
        sample_ch.final_sample = 1'b0;

        // shadow starts from the reset state of the block
        tap_count_q = TAP_COUNT_RESET;
        for (int i = 0; i < TAPS_MAX; i++)
        begin
            coefs_q[i] = '0;
            line_q[i]  = '0;
        end
        coefs_q[0] = coef_t'(COEF0_RESET);
        seen_q     = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_kernel();
        test_extreme_sums();
        test_tap_count_zero();
        test_config_mid_frame();
        test_output_backpressure();
        test_random_frames();

        wait_drained();
        if (mismatch_count == 0 && pending_outputs.size() == 0)
            $display("tb_centered_fir_convolution_unit OK");
        else
            $display("tb_centered_fir_convolution_unit NOT OK");
        $finish;
    end

endmodule
